// ===== hdl/srp_pkg.sv =====
// srp_pkg: beat types, status codes and character constants for the scale
// reply parser. No dependencies.
`default_nettype none

package srp_pkg;

    localparam int MAG_W = 40;
    localparam int DEC_W = 6;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_G_UC  = 8'h47;
    localparam logic [7:0] CH_G_LC  = 8'h67;
    localparam logic [7:0] CH_N_UC  = 8'h4E;
    localparam logic [7:0] CH_N_LC  = 8'h6E;
    localparam logic [7:0] CH_R_UC  = 8'h52;
    localparam logic [7:0] CH_R_LC  = 8'h72;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_byte;
        logic       no_reply;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [MAG_W-1:0] weight_magnitude;
        logic             weight_negative;
        logic [DEC_W-1:0] decimal_count;
        logic             unit_grains;
        logic             mantissa_saturated;
    } out_beat_t;

endpackage

`default_nettype wire

// ===== hdl/scale_response_parser.sv =====
// scale_response_parser: parses an ASCII weighing-scale reply, one byte per beat.
// Depends on srp_pkg (beat types, status codes, character constants).
//
//  channel | signals                     | beat
//  --------+-----------------------------+-----------------------------------
//  in      | in_valid, in_ready, in_data | one reply byte, last / timeout flags
//  out     | out_valid, out_ready, out_data | one parsed weight per reply
//
// One byte is accepted per cycle unless a closing beat is held (below); a byte is
// parsed in the input register, and the result register is loaded as the closing
// beat leaves it. The per-byte mantissa multiply-add is the longest path.
// Reset clears all parser state at once; no clearing pass.
// A closing beat waits in the input register while the result register is
// still held by out_ready low; other bytes keep flowing.
`default_nettype none

module scale_response_parser #(
    parameter int MAX_REPLY_BYTES = 63,
    parameter int MANTISSA_BITS   = 40
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire srp_pkg::in_beat_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output srp_pkg::out_beat_t     out_data
);

    localparam int CNT_W = $clog2(MAX_REPLY_BYTES + 1);
    localparam int EXT_W = MANTISSA_BITS + 4;
    localparam int DEC_W = srp_pkg::DEC_W;

    logic                     in_valid_reg;
    srp_pkg::in_beat_t        in_data_reg;
    logic                     out_valid_reg, out_valid_next;
    srp_pkg::out_beat_t       out_data_reg, out_data_next;

    logic [MANTISSA_BITS-1:0] mant_reg, mant_next;
    logic [DEC_W-1:0]         dec_reg, dec_next;
    logic                     sep_reg, sep_next;
    logic                     stop_reg, stop_next;
    logic                     minus_reg, minus_next;
    logic                     prev_g_reg, prev_g_next;
    logic                     grains_reg, grains_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     ended_reg, ended_next;
    logic                     ovf_reg, ovf_next;

    logic                     closing;
    logic                     advance;
    logic [7:0]               c;
    logic                     is_digit;
    logic [EXT_W-1:0]         mac;

    assign c        = in_data_reg.rx_byte;
    assign closing  = in_data_reg.no_reply | in_data_reg.last_byte;
    assign advance  = in_valid_reg & (~closing | ~out_valid_reg | out_ready);
    assign in_ready = ~in_valid_reg | advance;
    assign is_digit = (c >= srp_pkg::CH_ZERO) && (c <= srp_pkg::CH_NINE);

    // acc*10 + digit, overflow whenever the top bits are set
    assign mac = (EXT_W'(mant_reg) << 3) + (EXT_W'(mant_reg) << 1)
               + EXT_W'(c[3:0]);

    always_comb
    begin
        mant_next   = mant_reg;
        dec_next    = dec_reg;
        sep_next    = sep_reg;
        stop_next   = stop_reg;
        minus_next  = minus_reg;
        prev_g_next = prev_g_reg;
        grains_next = grains_reg;
        cnt_next    = cnt_reg;
        ended_next  = ended_reg;
        ovf_next    = ovf_reg;

        if (!in_data_reg.no_reply && !ended_reg
            && (cnt_reg < CNT_W'(MAX_REPLY_BYTES)))
        begin
            cnt_next = cnt_reg + 1'b1;
            if (c == srp_pkg::CH_NUL)
            begin
                ended_next = 1'b1;
            end
            else
            begin
                if (c == srp_pkg::CH_MINUS)
                begin
                    minus_next = 1'b1;
                end
                if (prev_g_reg && (c == srp_pkg::CH_N_LC || c == srp_pkg::CH_N_UC
                                   || c == srp_pkg::CH_R_LC || c == srp_pkg::CH_R_UC))
                begin
                    grains_next = 1'b1;
                end
                prev_g_next = (c == srp_pkg::CH_G_LC) || (c == srp_pkg::CH_G_UC);

                if (c == srp_pkg::CH_DOT || c == srp_pkg::CH_COMMA)
                begin
                    if (sep_reg)
                    begin
                        stop_next = 1'b1;
                    end
                    sep_next = 1'b1;
                end
                else if (is_digit && !stop_reg)
                begin
                    if (mac[EXT_W-1:MANTISSA_BITS] != '0)
                    begin
                        mant_next = '1;
                        ovf_next  = 1'b1;
                    end
                    else
                    begin
                        mant_next = mac[MANTISSA_BITS-1:0];
                    end
                    if (sep_reg && (dec_reg != '1))
                    begin
                        dec_next = dec_reg + 1'b1;
                    end
                end
            end
        end

        out_valid_next = out_valid_reg & ~out_ready;
        out_data_next  = out_data_reg;
        if (advance && closing)
        begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            if (in_data_reg.no_reply)
            begin
                out_data_next.status = srp_pkg::STATUS_TIMEOUT;
            end
            else if (!sep_next)
            begin
                out_data_next.status = srp_pkg::STATUS_INVALID;
            end
            else
            begin
                out_data_next.status             = srp_pkg::STATUS_OK;
                out_data_next.weight_magnitude   = srp_pkg::MAG_W'(mant_next);
                out_data_next.weight_negative    = minus_next;
                out_data_next.decimal_count      = dec_next;
                out_data_next.unit_grains        = grains_next;
                out_data_next.mantissa_saturated = ovf_next;
            end
            mant_next   = '0;
            dec_next    = '0;
            sep_next    = 1'b0;
            stop_next   = 1'b0;
            minus_next  = 1'b0;
            prev_g_next = 1'b0;
            grains_next = 1'b0;
            cnt_next    = '0;
            ended_next  = 1'b0;
            ovf_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mant_reg      <= '0;
            dec_reg       <= '0;
            sep_reg       <= 1'b0;
            stop_reg      <= 1'b0;
            minus_reg     <= 1'b0;
            prev_g_reg    <= 1'b0;
            grains_reg    <= 1'b0;
            cnt_reg       <= '0;
            ended_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                mant_reg   <= mant_next;
                dec_reg    <= dec_next;
                sep_reg    <= sep_next;
                stop_reg   <= stop_next;
                minus_reg  <= minus_next;
                prev_g_reg <= prev_g_next;
                grains_reg <= grains_next;
                cnt_reg    <= cnt_next;
                ended_reg  <= ended_next;
                ovf_reg    <= ovf_next;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_data_reg <= in_data;
        end
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== tb/scale_response_parser_test.sv =====
// scale_response_parser_test: self-checking testbench for the scale reply parser.
// Depends on srp_pkg and scale_response_parser; predicts each parsed weight per reply
// and checks every output beat against it under random idling and back-pressure.
`timescale 1ns / 100ps

module scale_response_parser_test;

    typedef logic [7:0] text_t[$];

    localparam int          MAX_TEXT = 63;
    localparam logic [63:0] MANT_MAX = (64'd1 << srp_pkg::MAG_W) - 64'd1;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    srp_pkg::in_beat_t  in_data;
    logic               out_valid;
    logic               out_ready;
    srp_pkg::out_beat_t out_data;

    srp_pkg::out_beat_t expected_weights[$];
    int                 errors = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 hold_len = 0;

    // predictor state
    logic [srp_pkg::MAG_W-1:0] acc_mant = '0;
    logic [srp_pkg::DEC_W-1:0] acc_decimals = '0;
    logic                      sep_seen = 1'b0;
    logic                      digits_frozen = 1'b0;
    logic                      neg_seen = 1'b0;
    logic                      last_was_g = 1'b0;
    logic                      grains_flag = 1'b0;
    logic [6:0]                bytes_taken = '0;
    logic                      text_done = 1'b0;
    logic                      sat_flag = 1'b0;

    scale_response_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("scale_response_parser_test NOT OK");
        $finish;
    end

    task automatic parse_reply_byte(input srp_pkg::in_beat_t b);
        srp_pkg::out_beat_t res;
        logic [63:0]        dig;
        logic [7:0]         c;
        c = b.rx_byte;
        if (!b.no_reply && !text_done && bytes_taken < MAX_TEXT)
        begin
            bytes_taken++;
            if (c == srp_pkg::CH_NUL)
                text_done = 1'b1;
            else
            begin
                if (c == srp_pkg::CH_MINUS)
                    neg_seen = 1'b1;
                if (last_was_g && (c == srp_pkg::CH_N_LC || c == srp_pkg::CH_N_UC
                                   || c == srp_pkg::CH_R_LC || c == srp_pkg::CH_R_UC))
                    grains_flag = 1'b1;
                last_was_g = (c == srp_pkg::CH_G_LC || c == srp_pkg::CH_G_UC);
                if (c == srp_pkg::CH_DOT || c == srp_pkg::CH_COMMA)
                begin
                    if (sep_seen)
                        digits_frozen = 1'b1;
                    sep_seen = 1'b1;
                end
                else if (c >= srp_pkg::CH_ZERO && c <= srp_pkg::CH_NINE && !digits_frozen)
                begin
                    dig = 64'(c - srp_pkg::CH_ZERO);
                    if (64'(acc_mant) > (MANT_MAX - dig) / 64'd10)
                    begin
                        acc_mant = '1;
                        sat_flag = 1'b1;
                    end
                    else
                        acc_mant = acc_mant * 40'd10 + dig[srp_pkg::MAG_W-1:0];
                    if (sep_seen && acc_decimals != '1)
                        acc_decimals++;
                end
            end
        end
        if (b.no_reply || b.last_byte)
        begin
            res = '0;
            if (b.no_reply)
                res.status = srp_pkg::STATUS_TIMEOUT;
            else if (!sep_seen)
                res.status = srp_pkg::STATUS_INVALID;
            else
            begin
                res.status             = srp_pkg::STATUS_OK;
                res.weight_magnitude   = acc_mant;
                res.weight_negative    = neg_seen;
                res.decimal_count      = acc_decimals;
                res.unit_grains        = grains_flag;
                res.mantissa_saturated = sat_flag;
            end
            expected_weights.push_back(res);
            acc_mant      = '0;
            acc_decimals  = '0;
            sep_seen      = 1'b0;
            digits_frozen = 1'b0;
            neg_seen      = 1'b0;
            last_was_g    = 1'b0;
            grains_flag   = 1'b0;
            bytes_taken   = '0;
            text_done     = 1'b0;
            sat_flag      = 1'b0;
        end
    endtask

    // entered and left at a falling edge; valid held high until the beat is taken
    task automatic send_beat(input srp_pkg::in_beat_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        parse_reply_byte(b);
        @(negedge clk);
    endtask

    task automatic send_reply(input text_t txt, input bit timed_out);
        srp_pkg::in_beat_t b;
        for (int i = 0; i < txt.size(); i++)
        begin
            b.rx_byte   = txt[i];
            b.last_byte = (i == txt.size() - 1) && !timed_out;
            b.no_reply  = 1'b0;
            send_beat(b);
        end
        if (timed_out)
        begin
            b.rx_byte   = 8'($urandom_range(255));
            b.last_byte = 1'($urandom_range(1));
            b.no_reply  = 1'b1;
            send_beat(b);
        end
    endtask

    function automatic text_t to_bytes(input string s);
        text_t t;
        for (int i = 0; i < s.len(); i++)
            t.push_back(s[i]);
        return t;
    endfunction

    function automatic void add_digits(ref text_t t, input int n);
        repeat (n) t.push_back(srp_pkg::CH_ZERO + 8'($urandom_range(9)));
    endfunction

    function automatic logic [7:0] pick_case(input logic [7:0] uc, input logic [7:0] lc);
        return $urandom_range(1) ? uc : lc;
    endfunction

    function automatic text_t random_reply();
        text_t t;
        int    kind;
        kind = $urandom_range(99);
        if (kind < 10)
        begin
            repeat ($urandom_range(1, 12)) t.push_back(8'($urandom_range(255)));
            return t;
        end
        repeat ($urandom_range(0, 2)) t.push_back(" ");
        if ($urandom_range(3) == 0)
            t.push_back(srp_pkg::CH_MINUS);
        add_digits(t, ($urandom_range(15) == 0) ? $urandom_range(10, 16)
                                                : $urandom_range(1, 6));
        if (kind >= 18)
        begin
            t.push_back($urandom_range(1) ? srp_pkg::CH_DOT : srp_pkg::CH_COMMA);
            add_digits(t, $urandom_range(0, 4));
            if ($urandom_range(9) == 0)
            begin
                t.push_back($urandom_range(1) ? srp_pkg::CH_DOT : srp_pkg::CH_COMMA);
                add_digits(t, $urandom_range(1, 3));
            end
        end
        if ($urandom_range(1))
            t.push_back(" ");
        case ($urandom_range(3))
            0: t.push_back(pick_case(srp_pkg::CH_G_UC, srp_pkg::CH_G_LC));
            1:
            begin
                t.push_back(pick_case(srp_pkg::CH_G_UC, srp_pkg::CH_G_LC));
                t.push_back(pick_case(srp_pkg::CH_N_UC, srp_pkg::CH_N_LC));
            end
            2:
            begin
                t.push_back(pick_case(srp_pkg::CH_G_UC, srp_pkg::CH_G_LC));
                t.push_back(pick_case(srp_pkg::CH_R_UC, srp_pkg::CH_R_LC));
            end
            default: t.push_back(8'($urandom_range(33, 126)));
        endcase
        if ($urandom_range(2) == 0)
        begin
            t.push_back(8'h0D);
            t.push_back(8'h0A);
        end
        if ($urandom_range(11) == 0)
            t.insert($urandom_range(t.size() - 1), srp_pkg::CH_NUL);
        return t;
    endfunction

    task automatic test_directed();
        text_t t;
        t.delete();
        send_reply(t, 1'b1);
        send_reply(to_bytes("-1,2gN"), 1'b0);
        send_reply(to_bytes("3.5"), 1'b1);
        t = to_bytes(".5");
        t.push_front(srp_pkg::CH_NUL);
        send_reply(t, 1'b0);
        send_reply(to_bytes("9.8.7Gr"), 1'b0);
        t = to_bytes("0.1");
        t.push_front(8'hFF);
        t.push_back(srp_pkg::CH_NUL);
        send_reply(t, 1'b0);
    endtask

    task automatic test_saturation();
        text_t t;
        send_reply(to_bytes("1099511627775.0"), 1'b0);
        send_reply(to_bytes("1099511627776."), 1'b0);
        send_reply(to_bytes("-109951162777.59g"), 1'b0);
        repeat (8)
        begin
            t.delete();
            add_digits(t, $urandom_range(12, 20));
            t.insert($urandom_range(t.size()), srp_pkg::CH_DOT);
            add_digits(t, $urandom_range(0, 3));
            send_reply(t, 1'b0);
        end
    endtask

    // text beyond the byte limit must be ignored, separator included
    task automatic test_long_reply();
        text_t t;
        repeat (3)
        begin
            t.delete();
            add_digits(t, $urandom_range(60, 85));
            t[$urandom_range(t.size() - 1)] = $urandom_range(1) ? srp_pkg::CH_DOT
                                                                : srp_pkg::CH_COMMA;
            send_reply(t, $urandom_range(5) == 0);
        end
    endtask

    task automatic test_random_replies(input int n, input int idle, input int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (n) send_reply(random_reply(), $urandom_range(11) == 0);
    endtask

    task automatic test_backpressure();
        text_t t;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len <= 300;
        repeat (20)
        begin
            t.delete();
            add_digits(t, 1);
            t.push_back(srp_pkg::CH_COMMA);
            add_digits(t, 1);
            send_reply(t, 1'b0);
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_len != 0)
        begin
            out_ready <= 1'b0;
            hold_len  <= hold_len - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic check_field(input string name, input logic [63:0] want, got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        srp_pkg::out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_weights.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat, expected none got status %0d",
                         $time, out_data.status);
            end
            else
            begin
                want = expected_weights.pop_front();
                check_field("status", want.status, out_data.status);
                check_field("weight_magnitude", want.weight_magnitude,
                            out_data.weight_magnitude);
                check_field("weight_negative", want.weight_negative,
                            out_data.weight_negative);
                check_field("decimal_count", want.decimal_count, out_data.decimal_count);
                check_field("unit_grains", want.unit_grains, out_data.unit_grains);
                check_field("mantissa_saturated", want.mantissa_saturated,
                            out_data.mantissa_saturated);
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_saturation();
        test_long_reply();
        test_random_replies(12, 0, 0);
        test_random_replies(12, 72, 0);
        test_random_replies(12, 0, 72);
        test_random_replies(12, 22, 22);
        test_backpressure();
        test_random_replies(5, 22, 22);

        in_valid <= 1'b0;
        while (expected_weights.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("scale_response_parser_test OK");
        else
            $display("scale_response_parser_test NOT OK");
        $finish;
    end

endmodule
